>>> hdl/tape_pulse_pair_byte_decoder_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tape pulse-pair byte decoder
// Concurrent checks on clk, disabled during rst; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef TAPE_PULSE_PAIR_BYTE_DECODER_MACROS_SVH
`define TAPE_PULSE_PAIR_BYTE_DECODER_MACROS_SVH
`ifndef SYNTHESIS
// check a property on every edge out of reset
`define TPD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check that a condition implies a consequence at the next edge
`define TPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TPD_ASSERT(label, prop, msg)
`define TPD_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> hdl/tpd_pkg.sv
// ----------------------------------------------------------------------------
// Tape pulse-pair decoder package
// Shared constants, event codes and the structs passed between stages.
// ----------------------------------------------------------------------------
package tpd_pkg;

  localparam logic [7:0] IDLE_LEVEL      = 8'd127;
  localparam logic [7:0] NOISE_LIMIT     = 8'd5;
  localparam logic [7:0] THRESHOLD_RESET = 8'd15;
  localparam logic [3:0] FRAME_BITS      = 4'd10;
  localparam logic [3:0] START_POS       = 4'd1;
  localparam logic [3:0] DATA_FIRST_POS  = 4'd2;
  localparam logic [3:0] DATA_LAST_POS   = 4'd9;

  typedef enum logic [1:0] {
    EV_GOOD     = 2'd0,
    EV_PARITY   = 2'd1,
    EV_START    = 2'd2,
    EV_BOUNDARY = 2'd3
  } event_kind_t;

  // one classified wave pair
  typedef struct packed {
    logic valid;
    logic is_sync;
    logic bit_value;
  } pair_t;

  typedef struct packed {
    logic        valid;
    event_kind_t kind;
    logic [7:0]  byte_value;
    logic [1:0]  block;
    logic        done;
  } result_t;

endpackage

>>> hdl/tpd_sample_if.sv
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel carrying one 8-bit unsigned audio sample per item.
// ----------------------------------------------------------------------------
interface tpd_sample_if;
  logic       valid;
  logic       ready;
  logic [7:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

>>> hdl/tpd_event_if.sv
// ----------------------------------------------------------------------------
// Event channel
// Valid/ready channel carrying one decoded byte, error or boundary item.
// ----------------------------------------------------------------------------
interface tpd_event_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [7:0] byte_value;
  logic [1:0] block_index;
  logic       set_done;

  modport source (output valid, output event_kind, output byte_value,
                  output block_index, output set_done, input ready);
  modport sink (input valid, input event_kind, input byte_value,
                input block_index, input set_done, output ready);
endinterface

>>> hdl/tpd_pair_detect.sv
// ----------------------------------------------------------------------------
// Wave pair detector
// Tracks rising-edge peaks, collects wave amplitudes in pairs, drops noise
// and sync overlap, and classifies each pair as sync, bit 1 or bit 0.
// ----------------------------------------------------------------------------
module tpd_pair_detect import tpd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       enable,
  input  logic [7:0] sample,
  input  logic [7:0] threshold,
  output pair_t      pair
);

  logic [7:0] previous_sample;
  logic [7:0] peak_high;
  logic [7:0] peak_low;
  logic [7:0] first_wave;
  logic [7:0] second_wave;
  logic       in_sync;

  logic [7:0] peak_high_next;
  logic [7:0] peak_low_next;
  logic [7:0] first_wave_next;
  logic [7:0] second_wave_next;
  logic       in_sync_next;
  logic [7:0] thr;
  logic [7:0] fw;
  logic [7:0] sw;
  logic [7:0] abs_diff;
  logic       pair_sync;

  always_comb begin
    thr = (threshold == 8'd0) ? 8'd1 : threshold;
    peak_high_next = peak_high;
    peak_low_next  = peak_low;
    fw = first_wave;
    sw = second_wave;
    in_sync_next = in_sync;
    pair = '0;

    if (sample > previous_sample) begin
      if (sample > peak_high) peak_high_next = sample;
      // the low mark takes the sample before the rise
      if (sample < peak_low) peak_low_next = previous_sample;
    end else if (first_wave == 8'd0) begin
      fw = peak_high - peak_low;
      peak_high_next = IDLE_LEVEL;
      peak_low_next  = IDLE_LEVEL;
    end else if (second_wave == 8'd0) begin
      sw = peak_high - peak_low;
    end

    // drop a noise wave, or a growing wave that overlaps sync
    if (fw != 8'd0 && sw != 8'd0) begin
      if (fw < NOISE_LIMIT || (in_sync && sw > fw && (sw - fw) > thr)) begin
        fw = sw;
        sw = 8'd0;
        peak_high_next = IDLE_LEVEL;
        peak_low_next  = IDLE_LEVEL;
      end
    end

    abs_diff  = (fw > sw) ? (fw - sw) : (sw - fw);
    pair_sync = abs_diff < thr;

    if (fw != 8'd0 && sw != 8'd0) begin
      pair.valid     = enable;
      pair.is_sync   = pair_sync;
      pair.bit_value = sw < fw;
      in_sync_next   = pair_sync;
      fw = 8'd0;
      sw = 8'd0;
      peak_high_next = IDLE_LEVEL;
      peak_low_next  = IDLE_LEVEL;
    end

    first_wave_next  = fw;
    second_wave_next = sw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_sample <= IDLE_LEVEL;
      peak_high       <= IDLE_LEVEL;
      peak_low        <= IDLE_LEVEL;
      first_wave      <= 8'd0;
      second_wave     <= 8'd0;
      in_sync         <= 1'b0;
    end else if (enable) begin
      previous_sample <= sample;
      peak_high       <= peak_high_next;
      peak_low        <= peak_low_next;
      first_wave      <= first_wave_next;
      second_wave     <= second_wave_next;
      in_sync         <= in_sync_next;
    end
  end

endmodule

>>> hdl/tpd_framer.sv
// ----------------------------------------------------------------------------
// Byte framer
// Assembles start, data and parity bits into bytes and numbers the blocks
// that sync pairs close.
// ----------------------------------------------------------------------------
module tpd_framer import tpd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  pair_t   pair,
  output result_t res
);

  `include "tape_pulse_pair_byte_decoder_macros.svh"

  logic [3:0] bit_position;
  logic [7:0] byte_shift;
  logic       start_bit;
  logic       parity_odd;
  logic [1:0] block_number;
  logic       block_has_bytes;

  logic [3:0] bit_position_next;
  logic [7:0] byte_shift_next;
  logic       start_bit_next;
  logic       parity_odd_next;
  logic [1:0] block_number_next;
  logic       block_has_bytes_next;
  logic [3:0] pos_inc;
  logic [2:0] data_index;

  always_comb begin
    bit_position_next    = bit_position;
    byte_shift_next      = byte_shift;
    start_bit_next       = start_bit;
    parity_odd_next      = parity_odd;
    block_number_next    = block_number;
    block_has_bytes_next = block_has_bytes;
    pos_inc    = bit_position + 4'd1;
    data_index = 3'(bit_position - 4'd1);
    res = '0;
    res.block = block_number;

    if (pair.valid && pair.is_sync) begin
      bit_position_next = 4'd0;
      byte_shift_next   = 8'd0;
      start_bit_next    = 1'b0;
      parity_odd_next   = 1'b0;
      // close a block only once it holds a good byte
      if (block_has_bytes) begin
        res.valid            = 1'b1;
        res.kind             = EV_BOUNDARY;
        res.done             = block_number == 2'd3;
        block_has_bytes_next = 1'b0;
        block_number_next    = block_number + 2'd1;
      end
    end else if (pair.valid) begin
      bit_position_next = pos_inc;
      if (pos_inc == START_POS) begin
        start_bit_next = pair.bit_value;
      end else if (pos_inc >= DATA_FIRST_POS && pos_inc <= DATA_LAST_POS) begin
        if (pair.bit_value) begin
          byte_shift_next[data_index] = 1'b1;
          parity_odd_next = ~parity_odd;
        end
      end else if (pos_inc == FRAME_BITS) begin
        res.valid = 1'b1;
        if (!start_bit) begin
          res.kind = EV_START;
        end else if (parity_odd ^ pair.bit_value) begin
          res.kind             = EV_GOOD;
          res.byte_value       = byte_shift;
          block_has_bytes_next = 1'b1;
        end else begin
          res.kind = EV_PARITY;
        end
        bit_position_next = 4'd0;
        byte_shift_next   = 8'd0;
        start_bit_next    = 1'b0;
        parity_odd_next   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_position    <= 4'd0;
      byte_shift      <= 8'd0;
      start_bit       <= 1'b0;
      parity_odd      <= 1'b0;
      block_number    <= 2'd0;
      block_has_bytes <= 1'b0;
    end else begin
      bit_position    <= bit_position_next;
      byte_shift      <= byte_shift_next;
      start_bit       <= start_bit_next;
      parity_odd      <= parity_odd_next;
      block_number    <= block_number_next;
      block_has_bytes <= block_has_bytes_next;
    end
  end

  `TPD_ASSERT(a_frame_closes, pair.valid && !pair.is_sync && bit_position == 4'd9 |-> res.valid, "tenth bit gave no frame result")
  `TPD_ASSERT(a_done_on_last, res.valid && res.done |-> res.kind == EV_BOUNDARY && res.block == 2'd3, "set_done outside the closing of block 3")
  `TPD_ASSERT_NEXT(a_block_advance, res.valid && res.kind == EV_BOUNDARY, block_number == 2'($past(block_number) + 2'd1) && !block_has_bytes, "block number did not advance on boundary")
  `TPD_ASSERT_NEXT(a_good_marks_block, res.valid && res.kind == EV_GOOD, block_has_bytes, "good byte did not mark its block")

endmodule

>>> hdl/tape_pulse_pair_byte_decoder.sv
// ----------------------------------------------------------------------------
// Tape pulse-pair byte decoder
// Decodes 8-bit cassette audio samples into framed bytes, errors and
// block boundaries.
// ----------------------------------------------------------------------------
//  channel    dir  payload                                           handshake
//  samples    in   sample[7:0]                                       valid/ready
//  events     out  event_kind[1:0] byte_value[7:0] block_index[1:0]
//                  set_done                                          valid/ready
//  cfg        in   cfg_wr_data[7:0] = threshold                      cfg_wr_en
//
//  One sample per cycle, sustained while events are not stalled; a result
//  passes through the input register, then the pair/frame logic into the
//  result register. Reset clears all decoder state and sets the threshold
//  to 15. A stalled result register holds the input stage, and a sample is
//  still taken in the cycle the waiting result leaves.
// ----------------------------------------------------------------------------
module tape_pulse_pair_byte_decoder import tpd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  tpd_sample_if.sink       samples,
  tpd_event_if.source      events,
  input  logic             cfg_wr_en,
  input  logic [7:0]       cfg_wr_data
);

  logic       pair_threshold;
  logic [7:0] threshold;
  logic       s1_valid;
  logic [7:0] s1_sample;
  logic       advance;
  pair_t      pair;
  result_t    res;

  logic        out_valid;
  event_kind_t out_kind;
  logic [7:0]  out_byte;
  logic [1:0]  out_block;
  logic        out_done;

  assign pair_threshold = cfg_wr_en;
  assign advance        = s1_valid && (!out_valid || events.ready);
  assign samples.ready  = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (pair_threshold) begin
      threshold <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (samples.ready) begin
      s1_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      s1_sample <= samples.sample;
    end
  end

  tpd_pair_detect u_pair_detect (
    .clk       (clk),
    .rst       (rst),
    .enable    (advance),
    .sample    (s1_sample),
    .threshold (threshold),
    .pair      (pair)
  );

  tpd_framer u_framer (
    .clk  (clk),
    .rst  (rst),
    .pair (pair),
    .res  (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res.valid;
    end else if (events.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_kind  <= res.kind;
      out_byte  <= res.byte_value;
      out_block <= res.block;
      out_done  <= res.done;
    end
  end

  assign events.valid       = out_valid;
  assign events.event_kind  = out_kind;
  assign events.byte_value  = out_byte;
  assign events.block_index = out_block;
  assign events.set_done    = out_done;

endmodule
